>>> sv/fat32_chain_read_sequencer_defines.svh
// Assertion macros shared by the FAT32 chain read sequencer RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef FAT32_CHAIN_READ_SEQUENCER_DEFINES_SVH
`define FAT32_CHAIN_READ_SEQUENCER_DEFINES_SVH

// Same-cycle implication under reset.
`define FCRS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under reset.
`define FCRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/fcrs_pkg.sv
// Shared types, codes and helpers of the FAT32 chain read sequencer.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package fcrs_pkg;

    localparam int SECTOR_BYTES_DEFAULT = 512;
    localparam int QUEUE_DEPTH_DEFAULT  = 4;

    localparam int CLUSTER_W = 28;
    localparam int LBA_W     = 32;
    localparam int LEFT_W    = 24;
    localparam int SPC_W     = 8;
    localparam int WORD_W    = 7;

    localparam logic [CLUSTER_W-1:0] END_MARK  = 28'hFFFFFF8;
    localparam logic [CLUSTER_W-1:0] TALLY_MAX = 28'hFFFFFFF;

    // input commands
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_ENTRY = 2'd1;
    localparam logic [1:0] CMD_FAIL  = 2'd2;

    // result kinds
    localparam logic [1:0] REQ_DATA  = 2'd0;
    localparam logic [1:0] REQ_FAT   = 2'd1;
    localparam logic [1:0] REQ_DONE  = 2'd2;
    localparam logic [1:0] REQ_ERROR = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_FAT_START  = 2'd0;
    localparam logic [1:0] CFG_DATA_START = 2'd1;
    localparam logic [1:0] CFG_SPC        = 2'd2;

    typedef enum logic [1:0] {
        JOB_VISIT,
        JOB_DONE,
        JOB_ERROR
    } job_kind_t;

    typedef struct packed {
        job_kind_t              kind;
        logic [CLUSTER_W-1:0]   cluster;
        logic [SPC_W-1:0]       count;
        logic [CLUSTER_W-1:0]   tally;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } push_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    function automatic logic chain_ends(input logic [CLUSTER_W-1:0] c);
        return (c == '0) || (c >= END_MARK);
    endfunction

endpackage

>>> sv/fcrs_queue.sv
// Short job queue between the front and back parts of the sequencer.
// Depends on fcrs_pkg for the job record and status types.
`timescale 1ns / 1ps

module fcrs_queue #(
    parameter int QUEUE_DEPTH = fcrs_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  fcrs_pkg::push_t                  push,
    input  logic                             pop,
    output fcrs_pkg::job_t                   head,
    output fcrs_pkg::q_status_t              status,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] count
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    fcrs_pkg::job_t   mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push.valid && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push.valid)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            mem_reg[wr_ptr_reg] <= push.job;
        end
    end

    assign head         = mem_reg[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign count        = count_reg;

endmodule

>>> sv/fcrs_front.sv
// Front part: accepts input beats, tracks the walk state and queues jobs.
// Depends on fcrs_pkg for codes, job records and the chain end test.
`timescale 1ns / 1ps

module fcrs_front #(
    parameter int SECTOR_BYTES = fcrs_pkg::SECTOR_BYTES_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        cmd,
    input  logic [fcrs_pkg::CLUSTER_W-1:0]    start_cluster,
    input  logic [31:0]                       file_size,
    input  logic [31:0]                       fat_entry,
    input  logic [fcrs_pkg::SPC_W-1:0]        sectors_per_cluster,
    input  fcrs_pkg::q_status_t               q_status,
    output fcrs_pkg::push_t                   push
);

    localparam int SECT_SHIFT = $clog2(SECTOR_BYTES);

    logic                            accept;
    logic                            active_reg;
    logic                            active_next;
    logic [fcrs_pkg::LEFT_W-1:0]     left_reg;
    logic [fcrs_pkg::LEFT_W-1:0]     left_next;
    logic [fcrs_pkg::CLUSTER_W-1:0]  tally_reg;
    logic [fcrs_pkg::CLUSTER_W-1:0]  tally_next;

    logic                            do_visit;
    logic [fcrs_pkg::CLUSTER_W-1:0]  visit_cluster;
    logic [fcrs_pkg::LEFT_W-1:0]     left_base;
    logic [fcrs_pkg::CLUSTER_W-1:0]  tally_base;
    logic [31:0]                     size_sectors;
    logic [fcrs_pkg::LEFT_W-1:0]     spc_wide;
    logic [fcrs_pkg::CLUSTER_W-1:0]  next_cluster;

    assign accept       = in_valid && !q_status.full;
    assign in_stall     = q_status.full;
    assign size_sectors = (file_size >> SECT_SHIFT) + 32'd1;
    assign spc_wide     = {{(fcrs_pkg::LEFT_W - fcrs_pkg::SPC_W){1'b0}}, sectors_per_cluster};
    assign next_cluster = fat_entry[fcrs_pkg::CLUSTER_W-1:0];

    always_comb
    begin
        active_next   = active_reg;
        left_next     = left_reg;
        tally_next    = tally_reg;
        do_visit      = 1'b0;
        visit_cluster = next_cluster;
        left_base     = left_reg;
        tally_base    = tally_reg;
        push.valid    = 1'b0;
        push.job      = '{kind: fcrs_pkg::JOB_DONE, cluster: '0, count: '0, tally: tally_reg};

        if (accept)
        begin
            case (cmd)
                fcrs_pkg::CMD_START:
                begin
                    left_base   = size_sectors[fcrs_pkg::LEFT_W-1:0];
                    tally_base  = '0;
                    left_next   = left_base;
                    tally_next  = '0;
                    if (fcrs_pkg::chain_ends(start_cluster))
                    begin
                        active_next   = 1'b0;
                        push.valid    = 1'b1;
                        push.job.tally = '0;
                    end
                    else
                    begin
                        active_next   = 1'b1;
                        do_visit      = 1'b1;
                        visit_cluster = start_cluster;
                    end
                end
                fcrs_pkg::CMD_ENTRY:
                begin
                    if (active_reg)
                    begin
                        if (fcrs_pkg::chain_ends(next_cluster))
                        begin
                            active_next = 1'b0;
                            push.valid  = 1'b1;
                        end
                        else
                        begin
                            do_visit = 1'b1;
                        end
                    end
                end
                fcrs_pkg::CMD_FAIL:
                begin
                    if (active_reg)
                    begin
                        active_next   = 1'b0;
                        push.valid    = 1'b1;
                        push.job.kind = fcrs_pkg::JOB_ERROR;
                    end
                end
                default:
                begin
                    // unused command: drop
                end
            endcase

            if (do_visit)
            begin
                tally_next = (tally_base == fcrs_pkg::TALLY_MAX) ? tally_base
                                                                 : tally_base + 1'b1;
                left_next  = (left_base >= spc_wide) ? left_base - spc_wide : '0;
                push.valid       = 1'b1;
                push.job.kind    = fcrs_pkg::JOB_VISIT;
                push.job.cluster = visit_cluster;
                push.job.count   = (left_base < spc_wide) ? left_base[fcrs_pkg::SPC_W-1:0]
                                                          : sectors_per_cluster;
                push.job.tally   = tally_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            left_reg   <= '0;
            tally_reg  <= '0;
        end
        else
        begin
            active_reg <= active_next;
            left_reg   <= left_next;
            tally_reg  <= tally_next;
        end
    end

endmodule

>>> sv/fcrs_back.sv
// Back part: turns queued jobs into request beats through an output register.
// Depends on fcrs_pkg for job records and result codes.
`timescale 1ns / 1ps

module fcrs_back #(
    parameter int SECTOR_BYTES = fcrs_pkg::SECTOR_BYTES_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  fcrs_pkg::job_t                    head,
    input  fcrs_pkg::q_status_t               q_status,
    output logic                              pop,
    input  logic [fcrs_pkg::LBA_W-1:0]        fat_start_sector,
    input  logic [fcrs_pkg::LBA_W-1:0]        first_data_sector,
    input  logic [fcrs_pkg::SPC_W-1:0]        sectors_per_cluster,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        request_kind,
    output logic [fcrs_pkg::LBA_W-1:0]        sector_address,
    output logic [fcrs_pkg::SPC_W-1:0]        sector_count,
    output logic [fcrs_pkg::WORD_W-1:0]       word_index,
    output logic [fcrs_pkg::CLUSTER_W-1:0]    clusters_seen,
    output logic                              last
);

    // four bytes per FAT entry
    localparam int FAT_SHIFT = $clog2(SECTOR_BYTES) - 2;

    // operand stage
    logic                            a_valid_reg;
    logic                            a_valid_next;
    fcrs_pkg::job_t                  a_job_reg;
    logic [fcrs_pkg::LBA_W-1:0]      a_prod_reg;
    logic [fcrs_pkg::LBA_W-1:0]      head_diff;
    logic [fcrs_pkg::LBA_W+fcrs_pkg::SPC_W-1:0] head_prod;

    // output register
    logic                            phase_reg;
    logic                            phase_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [1:0]                      kind_reg;
    logic [1:0]                      kind_next;
    logic [fcrs_pkg::LBA_W-1:0]      addr_reg;
    logic [fcrs_pkg::LBA_W-1:0]      addr_next;
    logic [fcrs_pkg::SPC_W-1:0]      count_reg;
    logic [fcrs_pkg::SPC_W-1:0]      count_next;
    logic [fcrs_pkg::WORD_W-1:0]     word_reg;
    logic [fcrs_pkg::WORD_W-1:0]     word_next;
    logic [fcrs_pkg::CLUSTER_W-1:0]  seen_reg;
    logic [fcrs_pkg::CLUSTER_W-1:0]  seen_next;
    logic                            last_reg;
    logic                            last_next;

    logic                            out_free;
    logic                            a_consume;
    logic [fcrs_pkg::LBA_W-1:0]      a_cluster_wide;
    logic [fcrs_pkg::LBA_W-1:0]      data_lba;
    logic [fcrs_pkg::LBA_W-1:0]      fat_lba;

    // (cluster - 2) wraps modulo 2^32 for clusters below two
    assign head_diff      = {{(fcrs_pkg::LBA_W - fcrs_pkg::CLUSTER_W){1'b0}}, head.cluster}
                            - fcrs_pkg::LBA_W'(2);
    assign head_prod      = head_diff * sectors_per_cluster;

    assign a_cluster_wide = {{(fcrs_pkg::LBA_W - fcrs_pkg::CLUSTER_W){1'b0}}, a_job_reg.cluster};
    assign data_lba       = a_prod_reg + first_data_sector;
    assign fat_lba        = fat_start_sector + (a_cluster_wide >> FAT_SHIFT);

    assign out_free  = !out_valid_reg || !out_stall;
    assign a_consume = out_free && a_valid_reg
                       && ((a_job_reg.kind != fcrs_pkg::JOB_VISIT) || phase_reg);
    assign pop       = !q_status.empty && (!a_valid_reg || a_consume);

    always_comb
    begin
        a_valid_next   = a_valid_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        addr_next      = addr_reg;
        count_next     = count_reg;
        word_next      = word_reg;
        seen_next      = seen_reg;
        last_next      = last_reg;

        if (pop)
        begin
            a_valid_next = 1'b1;
        end
        else if (a_consume)
        begin
            a_valid_next = 1'b0;
        end

        if (out_free)
        begin
            out_valid_next = a_valid_reg;
            seen_next      = a_job_reg.tally;
            addr_next      = '0;
            count_next     = '0;
            word_next      = '0;
            last_next      = 1'b1;
            case (a_job_reg.kind)
                fcrs_pkg::JOB_VISIT:
                begin
                    if (!phase_reg)
                    begin
                        kind_next  = fcrs_pkg::REQ_DATA;
                        addr_next  = data_lba;
                        count_next = a_job_reg.count;
                        last_next  = 1'b0;
                    end
                    else
                    begin
                        // word index is cluster mod (sector words); its low bits suffice
                        kind_next  = fcrs_pkg::REQ_FAT;
                        addr_next  = fat_lba;
                        count_next = fcrs_pkg::SPC_W'(1);
                        word_next  = a_job_reg.cluster[fcrs_pkg::WORD_W-1:0];
                    end
                    if (a_valid_reg)
                    begin
                        phase_next = !phase_reg;
                    end
                end
                fcrs_pkg::JOB_ERROR:
                begin
                    kind_next = fcrs_pkg::REQ_ERROR;
                end
                default:
                begin
                    kind_next = fcrs_pkg::REQ_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_job_reg  <= head;
            a_prod_reg <= head_prod[fcrs_pkg::LBA_W-1:0];
        end
        kind_reg  <= kind_next;
        addr_reg  <= addr_next;
        count_reg <= count_next;
        word_reg  <= word_next;
        seen_reg  <= seen_next;
        last_reg  <= last_next;
    end

    assign out_valid      = out_valid_reg;
    assign request_kind   = kind_reg;
    assign sector_address = addr_reg;
    assign sector_count   = count_reg;
    assign word_index     = word_reg;
    assign clusters_seen  = seen_reg;
    assign last           = last_reg;

endmodule

>>> sv/fat32_chain_read_sequencer.sv
// FAT32 chain read sequencer. A start beat (cmd 0) opens a walk of one
// file's cluster chain; for every live cluster the block issues a data read
// of the cluster (request_kind 0) followed by a FAT sector read (kind 1) that
// names the sector and 32-bit word holding the next link. The host returns
// that FAT word with cmd 1; zero or an end mark closes the walk with a done
// beat (kind 2), and cmd 2 aborts it with an error beat (kind 3). Entry and
// failure beats while no walk is open, and cmd 3, produce nothing. The final
// beat caused by an input carries last. Timing: a front part updates the walk
// state and queues at most one job per input in the cycle it is accepted, so
// input is taken every cycle until the job queue (QUEUE_DEPTH entries) fills.
// A back part drives one result beat per cycle from its output register while
// out_stall is low; a chain link yields a data read and a FAT read beat, a done
// or error job one beat. Jobs pass the queue, then the operand register, which
// holds the 32x8 data LBA multiply, then the output register.
// Configuration is written through cfg_we/cfg_index/cfg_data and must only
// change while the block is idle.
`timescale 1ns / 1ps
`include "fat32_chain_read_sequencer_defines.svh"

module fat32_chain_read_sequencer #(
    parameter int SECTOR_BYTES = fcrs_pkg::SECTOR_BYTES_DEFAULT,
    parameter int QUEUE_DEPTH  = fcrs_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,

    // configuration write port
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [31:0]                       cfg_data,

    // input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        cmd,
    input  logic [fcrs_pkg::CLUSTER_W-1:0]    start_cluster,
    input  logic [31:0]                       file_size,
    input  logic [31:0]                       fat_entry,

    // result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        request_kind,
    output logic [fcrs_pkg::LBA_W-1:0]        sector_address,
    output logic [fcrs_pkg::SPC_W-1:0]        sector_count,
    output logic [fcrs_pkg::WORD_W-1:0]       word_index,
    output logic [fcrs_pkg::CLUSTER_W-1:0]    clusters_seen,
    output logic                              last
);

    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // configuration registers
    logic [fcrs_pkg::LBA_W-1:0]  fat_start_reg;
    logic [fcrs_pkg::LBA_W-1:0]  fat_start_next;
    logic [fcrs_pkg::LBA_W-1:0]  data_start_reg;
    logic [fcrs_pkg::LBA_W-1:0]  data_start_next;
    logic [fcrs_pkg::SPC_W-1:0]  spc_reg;
    logic [fcrs_pkg::SPC_W-1:0]  spc_next;

    fcrs_pkg::push_t             q_push;
    fcrs_pkg::job_t              q_head;
    fcrs_pkg::q_status_t         q_status;
    logic                        q_pop;
    logic [QCNT_W-1:0]           q_count;

    // Decode the register index; writes to the unused index are dropped.
    always_comb
    begin
        fat_start_next  = fat_start_reg;
        data_start_next = data_start_reg;
        spc_next        = spc_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                fcrs_pkg::CFG_FAT_START:  fat_start_next  = cfg_data;
                fcrs_pkg::CFG_DATA_START: data_start_next = cfg_data;
                fcrs_pkg::CFG_SPC:        spc_next        = cfg_data[fcrs_pkg::SPC_W-1:0];
                default:
                begin
                    // no register here
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fat_start_reg  <= '0;
            data_start_reg <= '0;
            spc_reg        <= fcrs_pkg::SPC_W'(1);
        end
        else
        begin
            fat_start_reg  <= fat_start_next;
            data_start_reg <= data_start_next;
            spc_reg        <= spc_next;
        end
    end

    // Front: classify each accepted beat and advance the walk state.
    fcrs_front #(
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_front (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .cmd                 (cmd),
        .start_cluster       (start_cluster),
        .file_size           (file_size),
        .fat_entry           (fat_entry),
        .sectors_per_cluster (spc_reg),
        .q_status            (q_status),
        .push                (q_push)
    );

    // Queue: decouple input acceptance from output back-pressure.
    fcrs_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .pop    (q_pop),
        .head   (q_head),
        .status (q_status),
        .count  (q_count)
    );

    // Back: compute addresses and hand beats to the output register.
    fcrs_back #(
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .head                (q_head),
        .q_status            (q_status),
        .pop                 (q_pop),
        .fat_start_sector    (fat_start_reg),
        .first_data_sector   (data_start_reg),
        .sectors_per_cluster (spc_reg),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .request_kind        (request_kind),
        .sector_address      (sector_address),
        .sector_count        (sector_count),
        .word_index          (word_index),
        .clusters_seen       (clusters_seen),
        .last                (last)
    );

    // Queue occupancy never exceeds its depth.
    `FCRS_ASSERT_IMPLY(a_queue_bound, clk, rst_n, 1'b1, q_count <= QCNT_W'(QUEUE_DEPTH), "job queue overflow")
    // A taken data read is followed at once by the FAT read of the same cluster.
    `FCRS_ASSERT_NEXT(a_data_then_fat, clk, rst_n, out_valid && !out_stall && request_kind == fcrs_pkg::REQ_DATA, out_valid && request_kind == fcrs_pkg::REQ_FAT, "data read not followed by FAT read")
    // Only a data read leaves more beats pending for its input.
    `FCRS_ASSERT_IMPLY(a_last_kind, clk, rst_n, out_valid && !last, request_kind == fcrs_pkg::REQ_DATA, "non-final beat that is not a data read")

endmodule

>>> bench/tb.sv
// Self-checking bench for fat32_chain_read_sequencer: random and directed chain walks
// against a built-in request predictor, with bursty input and a stalling sink.
// Depends on fcrs_pkg and the sequencer RTL; needs nothing else.
`timescale 1ns / 1ps

module tb;

    localparam int SECTOR_BYTES     = fcrs_pkg::SECTOR_BYTES_DEFAULT;
    localparam int WORDS_PER_SECTOR = SECTOR_BYTES / 4;
    localparam int CLK_PERIOD       = 10;
    localparam int RESET_CYCLES     = 4;
    // An ignored beat makes no result; allow the front queue and the two-stage
    // back end to empty before touching the registers.
    localparam int SETTLE_CYCLES    = 16;
    localparam int CYCLE_LIMIT      = 600000;
    localparam int PHASE_BEATS      = 175;
    localparam int RANDOM_PHASES    = 7;

    // command code with no meaning; the block ignores it
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // One host-side command beat, fields in port order.
    typedef struct packed {
        logic [1:0]                     op;
        logic [fcrs_pkg::CLUSTER_W-1:0] first_cluster;
        logic [31:0]                    size_bytes;
        logic [31:0]                    entry_word;
    } host_beat_t;

    // One request beat leaving the sequencer.
    typedef struct packed {
        logic [1:0]                     kind;
        logic [fcrs_pkg::LBA_W-1:0]     lba;
        logic [fcrs_pkg::SPC_W-1:0]     count;
        logic [fcrs_pkg::WORD_W-1:0]    word;
        logic [fcrs_pkg::CLUSTER_W-1:0] seen;
        logic                           tail;
    } disk_req_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [1:0]                     cfg_index = '0;
    logic [31:0]                    cfg_data = '0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic [1:0]                     cmd = '0;
    logic [fcrs_pkg::CLUSTER_W-1:0] start_cluster = '0;
    logic [31:0]                    file_size = '0;
    logic [31:0]                    fat_entry = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [1:0]                     request_kind;
    logic [fcrs_pkg::LBA_W-1:0]     sector_address;
    logic [fcrs_pkg::SPC_W-1:0]     sector_count;
    logic [fcrs_pkg::WORD_W-1:0]    word_index;
    logic [fcrs_pkg::CLUSTER_W-1:0] clusters_seen;
    logic                           last;

    fat32_chain_read_sequencer u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .start_cluster  (start_cluster),
        .file_size      (file_size),
        .fat_entry      (fat_entry),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .request_kind   (request_kind),
        .sector_address (sector_address),
        .sector_count   (sector_count),
        .word_index     (word_index),
        .clusters_seen  (clusters_seen),
        .last           (last)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow of the register file and of the walk state
    // ------------------------------------------------------------------
    logic [31:0]                    fat_lba_reg  = '0;
    logic [31:0]                    data_lba_reg = '0;
    logic [7:0]                     spc_reg      = 8'd1;

    bit                             walking      = 1'b0;
    logic [fcrs_pkg::CLUSTER_W-1:0] walk_cluster = '0;
    logic [23:0]                    walk_left    = '0;
    logic [fcrs_pkg::CLUSTER_W-1:0] walk_tally   = '0;

    disk_req_t            requests_due[$];
    host_beat_t           pending[$];
    bit                   failed = 1'b0;

    // Traffic shaping knobs, set per phase.
    bit                   sender_idle = 1'b1;
    bit                   stall_on    = 1'b1;

    function automatic bit is_chain_end(input logic [fcrs_pkg::CLUSTER_W-1:0] c);
        return (c == '0) || (c >= fcrs_pkg::END_MARK);
    endfunction

    // Visit walk_cluster: data read of the whole cluster, then the FAT sector
    // read that fetches its link. Tally and countdown move before either beat.
    function automatic void issue_cluster_reads();
        logic [31:0] c32;
        logic [23:0] spc24;
        logic [7:0]  cnt;
        disk_req_t   rq;
        c32   = {4'd0, walk_cluster};
        spc24 = {16'd0, spc_reg};
        cnt   = (walk_left < spc24) ? walk_left[7:0] : spc_reg;
        if (walk_tally < fcrs_pkg::TALLY_MAX)
            walk_tally = walk_tally + 1'b1;
        // countdown saturates, so an over-long chain keeps issuing count 0
        walk_left = (walk_left >= spc24) ? walk_left - spc24 : '0;

        rq.kind  = fcrs_pkg::REQ_DATA;
        rq.lba   = (c32 - 32'd2) * {24'd0, spc_reg} + data_lba_reg;
        rq.count = cnt;
        rq.word  = '0;
        rq.seen  = walk_tally;
        rq.tail  = 1'b0;
        requests_due.push_back(rq);

        rq.kind  = fcrs_pkg::REQ_FAT;
        rq.lba   = fat_lba_reg + (c32 * 32'd4) / SECTOR_BYTES;
        rq.count = 8'd1;
        rq.word  = 7'(c32 % WORDS_PER_SECTOR);
        rq.tail  = 1'b1;
        requests_due.push_back(rq);
    endfunction

    function automatic void close_walk(input logic [1:0] kind);
        disk_req_t rq;
        rq.kind  = kind;
        rq.lba   = '0;
        rq.count = '0;
        rq.word  = '0;
        rq.seen  = walk_tally;
        rq.tail  = 1'b1;
        requests_due.push_back(rq);
    endfunction

    // Advance the shadow walk by one accepted host beat.
    function automatic void walk_host_beat(input host_beat_t b);
        case (b.op)
            fcrs_pkg::CMD_START:
            begin
                walk_tally   = '0;
                walk_cluster = b.first_cluster;
                walk_left    = 24'(b.size_bytes / SECTOR_BYTES + 1);
                if (is_chain_end(b.first_cluster))
                begin
                    walking = 1'b0;
                    close_walk(fcrs_pkg::REQ_DONE);
                end
                else
                begin
                    walking = 1'b1;
                    issue_cluster_reads();
                end
            end
            fcrs_pkg::CMD_ENTRY:
            begin
                if (walking)
                begin
                    if (is_chain_end(b.entry_word[fcrs_pkg::CLUSTER_W-1:0]))
                    begin
                        walking = 1'b0;
                        close_walk(fcrs_pkg::REQ_DONE);
                    end
                    else
                    begin
                        walk_cluster = b.entry_word[fcrs_pkg::CLUSTER_W-1:0];
                        issue_cluster_reads();
                    end
                end
            end
            fcrs_pkg::CMD_FAIL:
            begin
                if (walking)
                begin
                    walking = 1'b0;
                    close_walk(fcrs_pkg::REQ_ERROR);
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            failed = 1'b1;
        end
    endfunction

    function automatic void check_request();
        disk_req_t want;
        if (requests_due.size() == 0)
        begin
            $display("%0t: request beat with none due, expected nothing, got kind %0d lba %h",
                     $time, request_kind, sector_address);
            failed = 1'b1;
        end
        else
        begin
            want = requests_due.pop_front();
            check_field("request_kind",   want.kind,  request_kind);
            check_field("sector_address", want.lba,   sector_address);
            check_field("sector_count",   want.count, sector_count);
            check_field("word_index",     want.word,  word_index);
            check_field("clusters_seen",  want.seen,  clusters_seen);
            check_field("last",           want.tail,  last);
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: check the result beat first, since it belongs to older
    // input beats, then predict from the input beat taken at this edge.
    // ------------------------------------------------------------------
    bit beat_taken = 1'b0;

    always @(posedge clk)
    begin
        if (!rst_n)
            beat_taken <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
                check_request();
            beat_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall)
                walk_host_beat({cmd, start_cluster, file_size, fat_entry});
        end
    end

    // ------------------------------------------------------------------
    // Driver: present beats from the pending queue in bursts with gaps.
    // Hold the payload while stalled; advance only after a taken beat.
    // ------------------------------------------------------------------
    int         burst_left = 0;
    int         gap_left   = 0;
    host_beat_t next_beat;

    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (beat_taken || !in_valid)
        begin
            if (beat_taken && sender_idle)
            begin
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    gap_left   = $urandom_range(1, 12);
                    burst_left = $urandom_range(1, 16);
                end
            end
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending.size() > 0)
            begin
                next_beat      = pending.pop_front();
                in_valid      <= 1'b1;
                cmd           <= next_beat.op;
                start_cluster <= next_beat.first_cluster;
                file_size     <= next_beat.size_bytes;
                fat_entry     <= next_beat.entry_word;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Sink back-pressure: alternate stall and run stretches of random length.
    bit stall_level = 1'b0;
    int stall_run   = 0;

    always @(negedge clk)
    begin
        if (stall_run == 0)
        begin
            stall_level = ~stall_level;
            stall_run   = stall_level ? $urandom_range(1, 6) : $urandom_range(1, 10);
        end
        stall_run--;
        out_stall <= stall_on && stall_level;
    end

    // Watchdog.
    int cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void push_beat(input logic [1:0] op,
                                      input logic [fcrs_pkg::CLUSTER_W-1:0] cl,
                                      input logic [31:0] sz, input logic [31:0] ent);
        host_beat_t b;
        b.op            = op;
        b.first_cluster = cl;
        b.size_bytes    = sz;
        b.entry_word    = ent;
        pending.push_back(b);
    endfunction

    // Cluster that keeps the chain going; lean on low clusters and the top edge.
    function automatic logic [fcrs_pkg::CLUSTER_W-1:0] live_cluster();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            return 28'd1;
        else if (pick < 35)
            return 28'($urandom_range(2, 300));
        else if (pick < 42)
            return 28'($urandom_range(32'h0FFF_FFF0, 32'h0FFF_FFF7));
        else
            return 28'($urandom_range(2, 32'h0FFF_FFF7));
    endfunction

    function automatic logic [fcrs_pkg::CLUSTER_W-1:0] end_cluster();
        if ($urandom_range(0, 99) < 40)
            return '0;
        return 28'($urandom_range(32'h0FFF_FFF8, 32'h0FFF_FFFF));
    endfunction

    // Small sizes run the countdown dry inside a chain; large ones do not.
    function automatic logic [31:0] file_bytes();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return $urandom_range(0, 4096);
        else if (pick < 60)
            return $urandom_range(0, 32'h000F_FFFF);
        else
            return $urandom;
    endfunction

    // Mostly well-formed walks with random content; the rest is noise.
    task automatic queue_walks(input int n);
        int made;
        int links;
        int pick;
        made = 0;
        while (made < n)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                push_beat(fcrs_pkg::CMD_START, live_cluster(), file_bytes(), $urandom);
                links = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 8);
                repeat (links)
                    push_beat(fcrs_pkg::CMD_ENTRY, 28'($urandom), $urandom,
                              {4'($urandom), live_cluster()});
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    push_beat(fcrs_pkg::CMD_ENTRY, 28'($urandom), $urandom,
                              {4'($urandom), end_cluster()});
                else if (pick < 8)
                    push_beat(fcrs_pkg::CMD_FAIL, 28'($urandom), $urandom, $urandom);
                // otherwise leave the walk open; the next start abandons it
                made += links + 2;
            end
            else
            begin
                push_beat(2'($urandom), 28'($urandom), $urandom, $urandom);
                made++;
            end
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            fcrs_pkg::CFG_FAT_START:  fat_lba_reg  = val;
            fcrs_pkg::CFG_DATA_START: data_lba_reg = val;
            fcrs_pkg::CFG_SPC:        spc_reg      = val[7:0];
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_geometry(input logic [31:0] fat_v, input logic [31:0] data_v,
                                input logic [31:0] spc_v);
        write_reg(fcrs_pkg::CFG_FAT_START,  fat_v);
        write_reg(fcrs_pkg::CFG_DATA_START, data_v);
        write_reg(fcrs_pkg::CFG_SPC,        spc_v);
    endtask

    // Hold until every queued beat is taken and every request has arrived,
    // then let ignored beats drain out of the block.
    task automatic wait_drained();
        while (pending.size() != 0 || in_valid || requests_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        int          ph;
        logic [31:0] fat_v;
        logic [31:0] data_v;
        logic [31:0] spc_v;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed walk through the corner cases with a mid-size geometry.
        set_geometry(32'h0000_1000, 32'h0001_0000, 32'd4);
        push_beat(fcrs_pkg::CMD_ENTRY, '0, '0, 32'hFFFF_FFFF);     // entry with no walk: drop
        push_beat(fcrs_pkg::CMD_FAIL, '0, '0, '0);                  // failure with no walk: drop
        push_beat(CMD_UNUSED, '1, '1, '1);                          // unused command
        push_beat(fcrs_pkg::CMD_START, 28'd0, 32'd100, '0);         // empty start
        push_beat(fcrs_pkg::CMD_START, 28'hFFF_FFF8, 32'd100, '0);  // start on end mark
        push_beat(fcrs_pkg::CMD_START, 28'hFFF_FFFF, 32'hFFFF_FFFF, '0);
        push_beat(fcrs_pkg::CMD_START, 28'd2, 32'd0, '0);           // one sector, first cluster
        push_beat(fcrs_pkg::CMD_ENTRY, '0, '0, 32'hF000_0003);      // high nibble masked, count 0
        push_beat(fcrs_pkg::CMD_ENTRY, '0, '0, 32'h0000_007F);      // last word of a FAT sector
        push_beat(fcrs_pkg::CMD_ENTRY, '0, '0, 32'h0000_0080);      // first word of the next one
        push_beat(fcrs_pkg::CMD_ENTRY, '0, '0, 32'h0FFF_FFF7);      // highest live cluster
        push_beat(fcrs_pkg::CMD_ENTRY, '0, '0, 32'h0FFF_FFF8);      // end of chain
        push_beat(fcrs_pkg::CMD_ENTRY, '0, '0, 32'h0000_0010);      // after done: drop
        push_beat(fcrs_pkg::CMD_START, 28'd1, 32'hFFFF_FFFF, '0);   // cluster 1 wraps the LBA
        push_beat(fcrs_pkg::CMD_ENTRY, '0, '0, 32'hFFFF_FFF0);
        push_beat(fcrs_pkg::CMD_START, 28'd5, 32'd2047, '0);        // restart while walking
        push_beat(fcrs_pkg::CMD_ENTRY, '0, '0, 32'd6);
        push_beat(fcrs_pkg::CMD_FAIL, '0, '0, '0);                  // abort
        push_beat(fcrs_pkg::CMD_FAIL, '0, '0, '0);                  // second abort: drop
        push_beat(fcrs_pkg::CMD_START, 28'h0AB_CDEF, 32'h1234_5678, '0);
        push_beat(CMD_UNUSED, '0, '0, '0);                          // unused command mid-walk
        push_beat(fcrs_pkg::CMD_ENTRY, '0, '0, 32'd0);              // zero link ends the chain
        push_beat(fcrs_pkg::CMD_START, 28'hFFF_FFF7, 32'd511, '0);  // highest live start
        push_beat(fcrs_pkg::CMD_ENTRY, '0, '0, 32'h1000_0000);      // masks to zero: done
        push_beat(fcrs_pkg::CMD_START, 28'd2, 32'd1000, '0);        // leave this walk open
        wait_drained();

        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            fat_v  = $urandom;
            data_v = $urandom;
            spc_v  = $urandom_range(1, 128);
            case (ph)
                0:
                begin
                    fat_v  = '0;
                    data_v = '0;
                    spc_v  = 32'd1;
                end
                1:
                begin
                    fat_v  = '1;
                    data_v = '1;
                    spc_v  = 32'd128;
                end
                3:       spc_v = 32'd0;              // zero-size clusters
                4:       spc_v = 32'd255;            // beyond the legal range
                6:       spc_v = $urandom_range(1, 8);
                default:
                begin
                end
            endcase
            // phase 1 runs with neither side idling
            sender_idle = (ph % 3) != 1;
            stall_on    = (ph % 4) != 1;
            set_geometry(fat_v, data_v, spc_v);
            if (ph == 2)
            begin
                // pause the sender halfway until the sink has caught up
                queue_walks(PHASE_BEATS / 2);
                wait_drained();
                queue_walks(PHASE_BEATS / 2);
            end
            else
                queue_walks(PHASE_BEATS);
            wait_drained();
        end

        if (!failed)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
